// ===== hw/rtl/avaf_pkg.sv =====
// Shared types, widths and helper functions for the anchored viewport
// aspect-fit block. Used by every module under hw/rtl; depends on nothing.
package avaf_pkg;

  localparam int COORD_BITS = 16;
  localparam int POS_W      = COORD_BITS + 1;
  localparam int SPAN_W     = 15;
  localparam int SRC_W      = 16;
  localparam int ANCHOR_W   = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = (COORD_BITS > SPAN_W) ? COORD_BITS : SPAN_W;

  // Cross products, rounded dividend and restoring divider widths.
  localparam int PROD_W     = SPAN_W + SRC_W;
  localparam int REM_W      = PROD_W + 2;
  localparam int QUO_W      = SPAN_W + 1;
  localparam int DIV_BITS   = 2;
  localparam int DIV_STAGES = QUO_W / DIV_BITS;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MONITOR_LEFT    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MONITOR_TOP     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_MONITOR_SPAN_X  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_MONITOR_SPAN_Y  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_VIEWPORT_ON     = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_VIEWPORT_SPAN_X = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] CFG_VIEWPORT_SPAN_Y = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_POSITION = CFG_IDX_W'(7);

  // Alignment codes of one anchor axis.
  localparam logic [1:0] ALIGN_NEAR   = 2'd0;
  localparam logic [1:0] ALIGN_CENTER = 2'd1;
  localparam logic [1:0] ALIGN_FAR    = 2'd2;
  localparam logic [1:0] ALIGN_NONE   = 2'd3;

  typedef struct packed {
    logic [COORD_BITS-1:0] monitor_left;
    logic [COORD_BITS-1:0] monitor_top;
    logic [SPAN_W-1:0]     monitor_span_x;
    logic [SPAN_W-1:0]     monitor_span_y;
    logic                  viewport_on;
    logic [SPAN_W-1:0]     viewport_span_x;
    logic [SPAN_W-1:0]     viewport_span_y;
    logic [ANCHOR_W-1:0]   anchor_position;
  } avaf_cfg_t;

  typedef struct packed {
    logic [POS_W-1:0]  org_x;
    logic [POS_W-1:0]  org_y;
    logic [SPAN_W-1:0] span_x;
    logic [SPAN_W-1:0] span_y;
  } avaf_rect_t;

  // Per-word context carried alongside the arithmetic.
  typedef struct packed {
    avaf_rect_t rect;
    logic       src_zero;
    logic       fit_width;
  } avaf_ctx_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [REM_W-1:0] dvs;
    logic [QUO_W-1:0] quo;
    avaf_ctx_t        ctx;
  } avaf_div_t;

  // Column of the 3x3 anchor: anchor mod 3.
  function automatic logic [1:0] anchor_column(input logic [ANCHOR_W-1:0] a);
    logic [1:0] c;
    case (a)
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: c = ALIGN_NEAR;
      4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       c = ALIGN_CENTER;
      default:                              c = ALIGN_FAR;
    endcase
    return c;
  endfunction

  // Row of the 3x3 anchor; rows past the bottom get no offset.
  function automatic logic [1:0] anchor_row(input logic [ANCHOR_W-1:0] a);
    logic [1:0] r;
    case (a)
      4'd0, 4'd1, 4'd2: r = ALIGN_NEAR;
      4'd3, 4'd4, 4'd5: r = ALIGN_CENTER;
      4'd6, 4'd7, 4'd8: r = ALIGN_FAR;
      default:          r = ALIGN_NONE;
    endcase
    return r;
  endfunction

  // A zero span counts as one when fitting.
  function automatic logic [SPAN_W-1:0] fit_span(input logic [SPAN_W-1:0] s);
    return (s == '0) ? SPAN_W'(1) : s;
  endfunction

endpackage

// ===== hw/rtl/anchored_viewport_aspect_fit_core.sv =====
// Top level of the anchored viewport aspect-fit block: configuration registers,
// viewport, cross products, pipelined divider and centering. Uses avaf_pkg.
//
// Usage. Program the monitor rectangle, the viewport and the anchor through
// the write port (config_write, config_index, config_data) while no word is in
// flight. Each word on the source channel carries a source frame size; the
// block returns one destination rectangle word on the dest channel for it.
// A word is taken at a rising edge where its valid is high and its stall low.
//
// From acceptance of a source word to dest_valid, the word passes one stage for
// viewport placement, one for the two 16x15 cross products, one to
// select and form the rounded dividend, eight divider stages of two quotient
// bits each, and the centering stage that is also the output register.
// Throughput is one word per cycle unless dest_stall holds; every stage has
// its own valid bit and takes a new word whenever it is empty or its word moves on.
//
// Reset (rst, synchronous) empties the pipeline and loads the register
// defaults: a 1920x1080 monitor at the origin, viewport off, anchor centered.
// When the receiver stalls, the result word holds on the dest ports, the
// stages behind it fill up, and source_stall rises once the pipeline is full.
module anchored_viewport_aspect_fit_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                config_write,
  input  logic [avaf_pkg::CFG_IDX_W-1:0]      config_index,
  input  logic [avaf_pkg::CFG_DATA_W-1:0]     config_data,
  input  logic                                source_valid,
  output logic                                source_stall,
  input  logic [avaf_pkg::SRC_W-1:0]          source_span_x,
  input  logic [avaf_pkg::SRC_W-1:0]          source_span_y,
  output logic                                dest_valid,
  input  logic                                dest_stall,
  output logic signed [avaf_pkg::POS_W-1:0]   dest_left,
  output logic signed [avaf_pkg::POS_W-1:0]   dest_top,
  output logic [avaf_pkg::SPAN_W-1:0]         dest_span_x,
  output logic [avaf_pkg::SPAN_W-1:0]         dest_span_y
);
  import avaf_pkg::*;

  avaf_cfg_t  cfg;
  avaf_rect_t vp_rect;

  avaf_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .config_write (config_write),
    .config_index (config_index),
    .config_data  (config_data),
    .cfg          (cfg)
  );

  // The user must change configuration only while the pipeline is empty; the
  // block does not enforce it. The combinational viewport is sampled on entry.
  avaf_viewport u_viewport (
    .cfg  (cfg),
    .rect (vp_rect)
  );

  // Stage 1: viewport and source size.
  logic             vp_valid;
  logic             vp_ready;
  avaf_ctx_t        vp_ctx;
  logic [SRC_W-1:0] vp_sw;
  logic [SRC_W-1:0] vp_sh;

  // Stage 2: cross products.
  logic              mul_valid;
  logic              mul_ready;
  avaf_ctx_t         mul_ctx;
  logic [SRC_W-1:0]  mul_sw;
  logic [SRC_W-1:0]  mul_sh;
  logic [PROD_W-1:0] mul_wh;
  logic [PROD_W-1:0] mul_hw;

  // Stage 3 and the divider chain; element 0 carries the stage 3 register.
  logic              prep_ready;
  logic              prep_fit;
  logic [PROD_W-1:0] prep_num;
  logic [SRC_W-1:0]  prep_den;
  avaf_div_t         prep_word;
  logic              div_in_valid;
  avaf_div_t         div_in_word;
  logic              div_valid [0:DIV_STAGES];
  avaf_div_t         div_word  [0:DIV_STAGES];
  logic              div_take  [0:DIV_STAGES];

  // Final stage.
  logic              fin_ready;
  avaf_div_t         fin_word;
  logic [SPAN_W-1:0] fin_fw;
  logic [SPAN_W-1:0] fin_fh;
  logic [SPAN_W-1:0] fin_q;
  logic [SPAN_W-1:0] fin_ow;
  logic [SPAN_W-1:0] fin_oh;
  logic [POS_W-1:0]  fin_left;
  logic [POS_W-1:0]  fin_top;
  logic              dest_src_zero;

  assign vp_ready     = !vp_valid || mul_ready;
  assign source_stall = !vp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp_valid <= 1'b0;
    end else if (vp_ready) begin
      vp_valid <= source_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (vp_ready && source_valid) begin
      vp_ctx.rect      <= vp_rect;
      vp_ctx.src_zero  <= (source_span_x == '0) || (source_span_y == '0);
      vp_ctx.fit_width <= 1'b0;
      vp_sw            <= source_span_x;
      vp_sh            <= source_span_y;
    end
  end

  // Stage 2: Vw*Sh and Vh*Sw with zero viewport spans counted as one.
  assign mul_ready = !mul_valid || prep_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (mul_ready) begin
      mul_valid <= vp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_ready && vp_valid) begin
      mul_ctx <= vp_ctx;
      mul_sw  <= vp_sw;
      mul_sh  <= vp_sh;
      mul_wh  <= PROD_W'(fit_span(vp_ctx.rect.span_x)) * PROD_W'(vp_sh);
      mul_hw  <= PROD_W'(fit_span(vp_ctx.rect.span_y)) * PROD_W'(vp_sw);
    end
  end

  // Stage 3: pick the limiting axis and form round(num/den) as
  // (2*num + den) / (2*den). The divisor starts shifted to the top
  // quotient bit.
  assign prep_fit = (mul_wh <= mul_hw);
  assign prep_num = prep_fit ? mul_wh : mul_hw;
  assign prep_den = prep_fit ? mul_sw : mul_sh;

  always_comb begin
    prep_word.rem           = (REM_W'(prep_num) << 1) + REM_W'(prep_den);
    prep_word.dvs           = REM_W'({prep_den, 1'b0}) << (QUO_W - 1);
    prep_word.quo           = '0;
    prep_word.ctx           = mul_ctx;
    prep_word.ctx.fit_width = prep_fit;
  end

  assign prep_ready = !div_in_valid || div_take[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      div_in_valid <= 1'b0;
    end else if (prep_ready) begin
      div_in_valid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prep_ready && mul_valid) begin
      div_in_word <= prep_word;
    end
  end

  assign div_valid[0] = div_in_valid;
  assign div_word[0]  = div_in_word;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    avaf_div_stage u_stage (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (div_valid[k]),
      .up_word    (div_word[k]),
      .up_ready   (div_take[k]),
      .down_valid (div_valid[k+1]),
      .down_word  (div_word[k+1]),
      .down_ready (div_take[k+1])
    );
  end

  // Final stage: clamp the quotient to at least one, take the other side
  // from the fit rectangle and center with floor halving of the slack.
  assign fin_ready            = !dest_valid || !dest_stall;
  assign div_take[DIV_STAGES] = fin_ready;
  assign fin_word             = div_word[DIV_STAGES];

  assign fin_fw = fit_span(fin_word.ctx.rect.span_x);
  assign fin_fh = fit_span(fin_word.ctx.rect.span_y);
  assign fin_q  = fit_span(fin_word.quo[SPAN_W-1:0]);

  assign fin_ow = fin_word.ctx.fit_width ? fin_fw : fin_q;
  assign fin_oh = fin_word.ctx.fit_width ? fin_q  : fin_fh;

  always_comb begin
    if (fin_word.ctx.src_zero) begin
      fin_left = fin_word.ctx.rect.org_x;
      fin_top  = fin_word.ctx.rect.org_y;
    end else begin
      fin_left = fin_word.ctx.rect.org_x + POS_W'((fin_fw - fin_ow) >> 1);
      fin_top  = fin_word.ctx.rect.org_y + POS_W'((fin_fh - fin_oh) >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_valid <= 1'b0;
    end else if (fin_ready) begin
      dest_valid <= div_valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (fin_ready && div_valid[DIV_STAGES]) begin
      dest_left     <= fin_left;
      dest_top      <= fin_top;
      dest_span_x   <= fin_word.ctx.src_zero ? fin_word.ctx.rect.span_x : fin_ow;
      dest_span_y   <= fin_word.ctx.src_zero ? fin_word.ctx.rect.span_y : fin_oh;
      dest_src_zero <= fin_word.ctx.src_zero;
    end
  end

  // An accepted source word always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    source_valid && !source_stall |=> vp_valid)
    else $error("accepted source word did not enter the pipeline");

  // The rounded quotient never exceeds the fit span of the axis that it sizes.
  a_quotient_bound: assert property (@(posedge clk) disable iff (rst)
    div_valid[DIV_STAGES] && !fin_word.ctx.src_zero |->
      fin_word.quo <= QUO_W'(fin_word.ctx.fit_width ? fin_fh : fin_fw))
    else $error("divider quotient exceeds the fit span");

  // A fitted rectangle is never empty.
  a_fit_nonempty: assert property (@(posedge clk) disable iff (rst)
    dest_valid && !dest_src_zero |-> dest_span_x != '0 && dest_span_y != '0)
    else $error("fitted rectangle has a zero span");

endmodule

// ===== hw/rtl/avaf_cfg_regs.sv =====
// Configuration register file of the aspect-fit block with a plain write port.
// Depends on avaf_pkg.
module avaf_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            config_write,
  input  logic [avaf_pkg::CFG_IDX_W-1:0]  config_index,
  input  logic [avaf_pkg::CFG_DATA_W-1:0] config_data,
  output avaf_pkg::avaf_cfg_t             cfg
);
  import avaf_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.monitor_left    <= '0;
      cfg.monitor_top     <= '0;
      cfg.monitor_span_x  <= SPAN_W'(1920);
      cfg.monitor_span_y  <= SPAN_W'(1080);
      cfg.viewport_on     <= 1'b0;
      cfg.viewport_span_x <= '0;
      cfg.viewport_span_y <= '0;
      cfg.anchor_position <= ANCHOR_W'(4);
    end else if (config_write) begin
      case (config_index)
        CFG_MONITOR_LEFT:    cfg.monitor_left    <= config_data[COORD_BITS-1:0];
        CFG_MONITOR_TOP:     cfg.monitor_top     <= config_data[COORD_BITS-1:0];
        CFG_MONITOR_SPAN_X:  cfg.monitor_span_x  <= config_data[SPAN_W-1:0];
        CFG_MONITOR_SPAN_Y:  cfg.monitor_span_y  <= config_data[SPAN_W-1:0];
        CFG_VIEWPORT_ON:     cfg.viewport_on     <= config_data[0];
        CFG_VIEWPORT_SPAN_X: cfg.viewport_span_x <= config_data[SPAN_W-1:0];
        CFG_VIEWPORT_SPAN_Y: cfg.viewport_span_y <= config_data[SPAN_W-1:0];
        CFG_ANCHOR_POSITION: cfg.anchor_position <= config_data[ANCHOR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/avaf_viewport.sv =====
// Viewport selection: clamps the requested viewport to the monitor and places
// it by the 3x3 anchor. Combinational; depends on avaf_pkg.
module avaf_viewport (
  input  avaf_pkg::avaf_cfg_t  cfg,
  output avaf_pkg::avaf_rect_t rect
);
  import avaf_pkg::*;

  logic              use_vp;
  logic [SPAN_W-1:0] w;
  logic [SPAN_W-1:0] h;
  logic [SPAN_W-1:0] slack_x;
  logic [SPAN_W-1:0] slack_y;
  logic [SPAN_W-1:0] off_x;
  logic [SPAN_W-1:0] off_y;
  logic [POS_W-1:0]  base_x;
  logic [POS_W-1:0]  base_y;

  assign use_vp = cfg.viewport_on && (cfg.viewport_span_x != '0) &&
                  (cfg.viewport_span_y != '0);

  assign w = (cfg.viewport_span_x < cfg.monitor_span_x) ? cfg.viewport_span_x
                                                        : cfg.monitor_span_x;
  assign h = (cfg.viewport_span_y < cfg.monitor_span_y) ? cfg.viewport_span_y
                                                        : cfg.monitor_span_y;
  assign slack_x = cfg.monitor_span_x - w;
  assign slack_y = cfg.monitor_span_y - h;

  always_comb begin
    case (anchor_column(cfg.anchor_position))
      ALIGN_CENTER: off_x = slack_x >> 1;
      ALIGN_FAR:    off_x = slack_x;
      default:      off_x = '0;
    endcase
    case (anchor_row(cfg.anchor_position))
      ALIGN_CENTER: off_y = slack_y >> 1;
      ALIGN_FAR:    off_y = slack_y;
      default:      off_y = '0;
    endcase
  end

  assign base_x = {{(POS_W-COORD_BITS){cfg.monitor_left[COORD_BITS-1]}}, cfg.monitor_left};
  assign base_y = {{(POS_W-COORD_BITS){cfg.monitor_top[COORD_BITS-1]}}, cfg.monitor_top};

  assign rect.org_x  = use_vp ? base_x + POS_W'(off_x) : base_x;
  assign rect.org_y  = use_vp ? base_y + POS_W'(off_y) : base_y;
  assign rect.span_x = use_vp ? w : cfg.monitor_span_x;
  assign rect.span_y = use_vp ? h : cfg.monitor_span_y;

endmodule

// ===== hw/rtl/avaf_div_stage.sv =====
// One registered stage of the restoring divider: retires DIV_BITS quotient
// bits per word and holds its word while the next stage is full. Uses avaf_pkg.
module avaf_div_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  input  avaf_pkg::avaf_div_t up_word,
  output logic                up_ready,
  output logic                down_valid,
  output avaf_pkg::avaf_div_t down_word,
  input  logic                down_ready
);
  import avaf_pkg::*;

  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] dvs;
  logic [QUO_W-1:0] quo;
  avaf_div_t        step;

  // The shifted divisor walks down one bit per quotient bit.
  always_comb begin
    rem = up_word.rem;
    dvs = up_word.dvs;
    quo = up_word.quo;
    for (int j = 0; j < DIV_BITS; j++) begin
      if (rem >= dvs) begin
        rem = rem - dvs;
        quo = {quo[QUO_W-2:0], 1'b1};
      end else begin
        quo = {quo[QUO_W-2:0], 1'b0};
      end
      dvs = dvs >> 1;
    end
    step.rem = rem;
    step.dvs = dvs;
    step.quo = quo;
    step.ctx = up_word.ctx;
  end

  assign up_ready = !down_valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (up_ready) begin
      down_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      down_word <= step;
    end
  end

endmodule
